// ===== hdl/eap_pkg.sv =====
// ----------------------------------------------------------------------------
// eap_pkg
// Shared types, constants and the arctangent table of the elliptic arc point
// generator.
// ----------------------------------------------------------------------------
package eap_pkg;

	localparam int CORDIC_STAGES_DEF = 16;
	localparam int CORDIC_STAGES_MAX = 30;

	// widths of internal quantities
	localparam int ANGLE_W = 26;   // radians * 2^16, signed
	localparam int Z_W     = 34;   // radians * 2^30, signed
	localparam int XY_W    = 34;   // CORDIC x/y, Q30 signed

	// angle constants
	localparam longint SPAN_TWO_PI = 411775;
	localparam longint Q30_TWO_PI  = 64'd6746518852;
	localparam longint Q30_PI      = 64'd3373259426;
	localparam longint Q30_HALF_PI = 64'd1686629713;
	localparam longint Q30_GAIN    = 652032874;

	// floor(v / 411775) as (v * RECIP_M) >> RECIP_SHIFT, good to within one
	localparam longint RECIP_M     = 10680704;
	localparam int     RECIP_SHIFT = 42;
	localparam longint DIFF_BIAS   = 41 * SPAN_TWO_PI;
	localparam longint ANGLE_TURNS = 23;
	localparam longint ANGLE_BIAS  = ANGLE_TURNS * SPAN_TWO_PI;

	// atan(2^-i) in Q30, rounded
	localparam logic [31:0] ATAN_Q30 [CORDIC_STAGES_MAX + 1] = '{
		32'd843314857, 32'd497837829, 32'd263043837, 32'd133525159, 32'd67021687,
		32'd33543516, 32'd16775851, 32'd8388437, 32'd4194283, 32'd2097149,
		32'd1048576, 32'd524288, 32'd262144, 32'd131072, 32'd65536,
		32'd32768, 32'd16384, 32'd8192, 32'd4096, 32'd2048,
		32'd1024, 32'd512, 32'd256, 32'd128, 32'd64,
		32'd32, 32'd16, 32'd8, 32'd4, 32'd2,
		32'd1
	};

	typedef enum logic [2:0] {
		REG_CENTER_X    = 3'd0,
		REG_CENTER_Y    = 3'd1,
		REG_RADIUS_X    = 3'd2,
		REG_RADIUS_Y    = 3'd3,
		REG_START_ANGLE = 3'd4,
		REG_END_ANGLE   = 3'd5,
		REG_CLOCKWISE   = 3'd6,
		REG_ROTATION    = 3'd7
	} reg_idx_t;

	typedef struct packed {
		logic signed [31:0] center_x;
		logic signed [31:0] center_y;
		logic        [30:0] radius_x;
		logic        [30:0] radius_y;
		logic signed [23:0] start_angle;
		logic signed [23:0] end_angle;
		logic               clockwise;
		logic signed [23:0] rotation;
	} arc_cfg_t;

endpackage

// ===== hdl/eap_if.sv =====
// ----------------------------------------------------------------------------
// eap_if
// Valid/ready channels of the elliptic arc point generator.
// ----------------------------------------------------------------------------
interface eap_sample_if;
	logic        valid;
	logic        ready;
	logic [16:0] param_t;
	modport source (output valid, output param_t, input ready);
	modport sink (input valid, input param_t, output ready);
endinterface

interface eap_point_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] point_x;
	logic signed [31:0] point_y;
	modport source (output valid, output point_x, output point_y, input ready);
	modport sink (input valid, input point_x, input point_y, output ready);
endinterface

interface eap_cfg_if;
	logic        valid;
	logic        ready;
	logic [2:0]  index;
	logic [31:0] data;
	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

// ===== hdl/eap_front.sv =====
// ----------------------------------------------------------------------------
// eap_front
// Arc span reduction and curve angle, three pipeline stages.
// ----------------------------------------------------------------------------
module eap_front
	import eap_pkg::*;
(
	input  logic                      clk,
	input  logic                      en,
	input  logic [16:0]               param_t,
	input  arc_cfg_t                  cfg,
	output logic signed [ANGLE_W-1:0] angle
);

	localparam logic [18:0] TWO_PI_19 = 19'(SPAN_TWO_PI);

	logic [16:0]        t_s1, t_s2;
	logic [25:0]        ud_s1;
	logic [6:0]         qd_s1;
	logic               dz_s1;
	logic signed [19:0] span_s2;
	logic signed [ANGLE_W-1:0] angle_s3;

	logic signed [24:0] diff;
	logic [25:0]        ud;
	logic [49:0]        qprod;
	logic signed [26:0] rem;
	logic [18:0]        rem19;
	logic signed [19:0] span;
	logic signed [37:0] tprod;
	logic signed [37:0] tshift;

	always_comb begin
		diff  = 25'(cfg.end_angle) - 25'(cfg.start_angle);
		ud    = 26'($signed(diff) + 26'(DIFF_BIAS));
		qprod = 50'(ud) * 50'(RECIP_M);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			t_s1  <= param_t;
			ud_s1 <= ud;
			qd_s1 <= qprod[RECIP_SHIFT+6:RECIP_SHIFT];
			dz_s1 <= (diff == '0);
		end
	end

	// remainder of the difference, then span in [-2pi, 2pi]
	always_comb begin
		rem = $signed({1'b0, ud_s1}) - $signed({1'b0, 26'(qd_s1) * 26'(TWO_PI_19)});
		if (rem < 0) begin
			rem = rem + 27'(SPAN_TWO_PI);
		end
		rem19 = rem[18:0];
		if (dz_s1) begin
			span = '0;
		end else begin
			span = (rem19 == '0) ? 20'(SPAN_TWO_PI) : $signed({1'b0, rem19});
			if (cfg.clockwise) begin
				span = (span == 20'(SPAN_TWO_PI)) ? -20'(SPAN_TWO_PI)
				                                  : span - 20'(SPAN_TWO_PI);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			t_s2    <= t_s1;
			span_s2 <= span;
		end
	end

	always_comb begin
		tprod  = $signed({21'd0, t_s2}) * 38'(span_s2);
		tshift = (tprod + 38'sd32768) >>> 16;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			angle_s3 <= ANGLE_W'(cfg.start_angle) + tshift[ANGLE_W-1:0];
		end
	end

	assign angle = angle_s3;

endmodule

// ===== hdl/eap_reduce.sv =====
// ----------------------------------------------------------------------------
// eap_reduce
// Angle to Q30, reduced modulo 2pi and folded into [-pi/2, pi/2].
// Four pipeline stages.
// ----------------------------------------------------------------------------
module eap_reduce
	import eap_pkg::*;
(
	input  logic                      clk,
	input  logic                      en,
	input  logic signed [ANGLE_W-1:0] angle,
	output logic signed [Z_W-1:0]     z,
	output logic                      neg
);

	localparam logic signed [41:0] TP   = 42'(Q30_TWO_PI);
	localparam logic signed [Z_W-1:0] PI_Z   = Z_W'(Q30_PI);
	localparam logic signed [Z_W-1:0] TP_Z   = Z_W'(Q30_TWO_PI);
	localparam logic signed [Z_W-1:0] HALF_Z = Z_W'(Q30_HALF_PI);

	logic signed [ANGLE_W-1:0] angle_r1;
	logic [5:0]                q_r1;
	logic signed [41:0]        r_r2;
	logic signed [Z_W-1:0]     z_r3;
	logic signed [Z_W-1:0]     z_r4;
	logic                      neg_r4;

	logic signed [ANGLE_W-1:0] a_s;
	logic [48:0]               qprod;
	logic signed [41:0]        u;
	logic [38:0]               qt;
	logic signed [41:0]        rc;
	logic signed [Z_W-1:0]     w;
	logic                      wn;

	always_comb begin
		a_s   = angle + ANGLE_W'(ANGLE_BIAS);
		qprod = 49'(a_s[ANGLE_W-2:0]) * 49'(RECIP_M);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			angle_r1 <= angle;
			q_r1     <= qprod[RECIP_SHIFT+5:RECIP_SHIFT];
		end
	end

	// estimate may be one turn off either way
	always_comb begin
		u  = (42'(angle_r1) <<< 14) + 42'(ANGLE_TURNS * Q30_TWO_PI);
		qt = 39'(q_r1) * 39'(Q30_TWO_PI);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			r_r2 <= u - $signed({3'd0, qt});
		end
	end

	always_comb begin
		if (r_r2 < 0) begin
			rc = r_r2 + TP;
		end else if (r_r2 >= TP) begin
			rc = r_r2 - TP;
		end else begin
			rc = r_r2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			z_r3 <= rc[Z_W-1:0];
		end
	end

	always_comb begin
		w  = (z_r3 > PI_Z) ? z_r3 - TP_Z : z_r3;
		wn = 1'b0;
		if (w > HALF_Z) begin
			w  = w - PI_Z;
			wn = 1'b1;
		end else if (w < -HALF_Z) begin
			w  = w + PI_Z;
			wn = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			z_r4   <= w;
			neg_r4 <= wn;
		end
	end

	assign z   = z_r4;
	assign neg = neg_r4;

endmodule

// ===== hdl/eap_cordic.sv =====
// ----------------------------------------------------------------------------
// eap_cordic
// Rotation-mode CORDIC, one register stage per iteration.
// ----------------------------------------------------------------------------
module eap_cordic
	import eap_pkg::*;
#(
	parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
	input  logic                   clk,
	input  logic                   en,
	input  logic signed [Z_W-1:0]  z_in,
	input  logic                   neg_in,
	output logic signed [XY_W-1:0] cos_out,
	output logic signed [XY_W-1:0] sin_out,
	output logic                   neg_out
);

	logic signed [XY_W-1:0] x_s [CORDIC_STAGES];
	logic signed [XY_W-1:0] y_s [CORDIC_STAGES];
	logic signed [Z_W-1:0]  z_s [CORDIC_STAGES];
	logic                   n_s [CORDIC_STAGES];

	genvar i;
	generate
		for (i = 0; i < CORDIC_STAGES; i++) begin : g_stage
			logic signed [XY_W-1:0] xi, yi, xs, ys;
			logic signed [Z_W-1:0]  zi, at;
			logic                   ni;

			if (i == 0) begin : g_first
				assign xi = XY_W'(Q30_GAIN);
				assign yi = '0;
				assign zi = z_in;
				assign ni = neg_in;
			end else begin : g_next
				assign xi = x_s[i-1];
				assign yi = y_s[i-1];
				assign zi = z_s[i-1];
				assign ni = n_s[i-1];
			end

			assign xs = xi >>> i;
			assign ys = yi >>> i;
			assign at = $signed({2'b00, ATAN_Q30[i]});

			always_ff @(posedge clk) begin
				if (en) begin
					if (zi >= 0) begin
						x_s[i] <= xi - ys;
						y_s[i] <= yi + xs;
						z_s[i] <= zi - at;
					end else begin
						x_s[i] <= xi + ys;
						y_s[i] <= yi - xs;
						z_s[i] <= zi + at;
					end
					n_s[i] <= ni;
				end
			end
		end
	endgenerate

	assign cos_out = x_s[CORDIC_STAGES-1];
	assign sin_out = y_s[CORDIC_STAGES-1];
	assign neg_out = n_s[CORDIC_STAGES-1];

endmodule

// ===== hdl/eap_offset.sv =====
// ----------------------------------------------------------------------------
// eap_offset
// Radius scaling, rotation about the center and saturating add.
// Four pipeline stages, the last one is the output register.
// ----------------------------------------------------------------------------
module eap_offset
	import eap_pkg::*;
(
	input  logic                   clk,
	input  logic                   en,
	input  arc_cfg_t               cfg,
	input  logic signed [XY_W-1:0] cos_in,
	input  logic signed [XY_W-1:0] sin_in,
	input  logic                   neg_in,
	input  logic signed [XY_W-1:0] rcos_in,
	input  logic signed [XY_W-1:0] rsin_in,
	input  logic                   rneg_in,
	output logic signed [31:0]     point_x,
	output logic signed [31:0]     point_y
);

	localparam logic signed [65:0] RND66 = 66'sd536870912;
	localparam logic signed [68:0] RND69 = 69'sd536870912;

	logic signed [65:0] px_s1, py_s1;
	logic signed [XY_W-1:0] rc_s1, rs_s1;
	logic signed [33:0] dx_s2, dy_s2;
	logic signed [67:0] pxc_s2, pys_s2, pxs_s2, pyc_s2;
	logic signed [35:0] ox_s3, oy_s3;
	logic signed [31:0] px_s4, py_s4;

	logic signed [XY_W-1:0] c, s;
	logic signed [65:0] dxw, dyw;
	logic signed [68:0] rx, ry;
	logic signed [36:0] sx, sy;

	always_comb begin
		c = neg_in ? -cos_in : cos_in;
		s = neg_in ? -sin_in : sin_in;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			px_s1 <= $signed({35'd0, cfg.radius_x}) * 66'(c);
			py_s1 <= $signed({35'd0, cfg.radius_y}) * 66'(s);
			rc_s1 <= rneg_in ? -rcos_in : rcos_in;
			rs_s1 <= rneg_in ? -rsin_in : rsin_in;
		end
	end

	always_comb begin
		dxw = (px_s1 + RND66) >>> 30;
		dyw = (py_s1 + RND66) >>> 30;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dx_s2  <= dxw[33:0];
			dy_s2  <= dyw[33:0];
			pxc_s2 <= 68'($signed(dxw[33:0])) * 68'(rc_s1);
			pys_s2 <= 68'($signed(dyw[33:0])) * 68'(rs_s1);
			pxs_s2 <= 68'($signed(dxw[33:0])) * 68'(rs_s1);
			pyc_s2 <= 68'($signed(dyw[33:0])) * 68'(rc_s1);
		end
	end

	always_comb begin
		rx = (69'(pxc_s2) - 69'(pys_s2) + RND69) >>> 30;
		ry = (69'(pxs_s2) + 69'(pyc_s2) + RND69) >>> 30;
	end

	// no rotation: pass the offset unchanged
	always_ff @(posedge clk) begin
		if (en) begin
			ox_s3 <= (cfg.rotation == '0) ? 36'(dx_s2) : rx[35:0];
			oy_s3 <= (cfg.rotation == '0) ? 36'(dy_s2) : ry[35:0];
		end
	end

	always_comb begin
		sx = 37'(cfg.center_x) + 37'(ox_s3);
		sy = 37'(cfg.center_y) + 37'(oy_s3);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (sx > 37'sd2147483647) begin
				px_s4 <= 32'sh7fffffff;
			end else if (sx < -37'sd2147483648) begin
				px_s4 <= 32'sh80000000;
			end else begin
				px_s4 <= sx[31:0];
			end
			if (sy > 37'sd2147483647) begin
				py_s4 <= 32'sh7fffffff;
			end else if (sy < -37'sd2147483648) begin
				py_s4 <= 32'sh80000000;
			end else begin
				py_s4 <= sy[31:0];
			end
		end
	end

	assign point_x = px_s4;
	assign point_y = py_s4;

endmodule

// ===== hdl/ellipse_arc_point.sv =====
// ----------------------------------------------------------------------------
// ellipse_arc_point
// Point on a configured, optionally rotated elliptic arc at parameter t.
// ----------------------------------------------------------------------------
// Usage: write the arc registers over cfg (index 0..7: center_x, center_y,
// radius_x, radius_y, start_angle, end_angle, clockwise, rotation) while no
// beat is in flight; cfg is always ready. Each beat on sample carries one
// param_t (Q1.16, unsigned) and yields exactly one beat on point with point_x and
// point_y in Q16.16, saturated.
// One beat is taken every cycle while the pipeline is not held. The pipeline
// is made up of the span stages, the angle reduction, one CORDIC stage per
// iteration (two CORDICs side by side, one for the curve angle and one for
// the rotation) and the multiply and saturate stages.
// When point is not ready and a result waits, the whole pipeline holds and
// sample.ready drops; no beat is lost or repeated.
// Reset clears the pipeline valid bits and loads the register defaults
// (unit radii, full turn from angle zero, no rotation).
// ----------------------------------------------------------------------------
module ellipse_arc_point
	import eap_pkg::*;
#(
	parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	eap_sample_if.sink  sample,
	eap_point_if.source point,
	eap_cfg_if.sink     cfg
);

	localparam int DEPTH = CORDIC_STAGES + 11;

	arc_cfg_t cfg_q;
	logic [DEPTH-1:0] valid_q;
	logic en;

	logic signed [ANGLE_W-1:0] angle;
	logic signed [ANGLE_W-1:0] rot_angle;
	logic signed [Z_W-1:0]     z, rz;
	logic                      zneg, rzneg;
	logic signed [XY_W-1:0]    cs, sn, rcs, rsn;
	logic                      cneg, rcneg;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.center_x    <= '0;
			cfg_q.center_y    <= '0;
			cfg_q.radius_x    <= 31'd65536;
			cfg_q.radius_y    <= 31'd65536;
			cfg_q.start_angle <= '0;
			cfg_q.end_angle   <= 24'(SPAN_TWO_PI);
			cfg_q.clockwise   <= 1'b0;
			cfg_q.rotation    <= '0;
		end else if (cfg.valid) begin
			case (reg_idx_t'(cfg.index))
				REG_CENTER_X:    cfg_q.center_x    <= cfg.data;
				REG_CENTER_Y:    cfg_q.center_y    <= cfg.data;
				REG_RADIUS_X:    cfg_q.radius_x    <= cfg.data[30:0];
				REG_RADIUS_Y:    cfg_q.radius_y    <= cfg.data[30:0];
				REG_START_ANGLE: cfg_q.start_angle <= cfg.data[23:0];
				REG_END_ANGLE:   cfg_q.end_angle   <= cfg.data[23:0];
				REG_CLOCKWISE:   cfg_q.clockwise   <= cfg.data[0];
				REG_ROTATION:    cfg_q.rotation    <= cfg.data[23:0];
				default: ;
			endcase
		end
	end

	// advance everything unless a finished result is blocked
	assign en           = !valid_q[DEPTH-1] || point.ready;
	assign sample.ready = en;
	assign point.valid  = valid_q[DEPTH-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (en) begin
			valid_q <= {valid_q[DEPTH-2:0], sample.valid};
		end
	end

	assign rot_angle = ANGLE_W'(cfg_q.rotation);

	eap_front u_front (
		.clk     (clk),
		.en      (en),
		.param_t (sample.param_t),
		.cfg     (cfg_q),
		.angle   (angle)
	);

	eap_reduce u_reduce (
		.clk   (clk),
		.en    (en),
		.angle (angle),
		.z     (z),
		.neg   (zneg)
	);

	eap_reduce u_rot_reduce (
		.clk   (clk),
		.en    (en),
		.angle (rot_angle),
		.z     (rz),
		.neg   (rzneg)
	);

	eap_cordic #(.CORDIC_STAGES(CORDIC_STAGES)) u_cordic (
		.clk     (clk),
		.en      (en),
		.z_in    (z),
		.neg_in  (zneg),
		.cos_out (cs),
		.sin_out (sn),
		.neg_out (cneg)
	);

	eap_cordic #(.CORDIC_STAGES(CORDIC_STAGES)) u_rot_cordic (
		.clk     (clk),
		.en      (en),
		.z_in    (rz),
		.neg_in  (rzneg),
		.cos_out (rcs),
		.sin_out (rsn),
		.neg_out (rcneg)
	);

	eap_offset u_offset (
		.clk     (clk),
		.en      (en),
		.cfg     (cfg_q),
		.cos_in  (cs),
		.sin_in  (sn),
		.neg_in  (cneg),
		.rcos_in (rcs),
		.rsin_in (rsn),
		.rneg_in (rcneg),
		.point_x (point.point_x),
		.point_y (point.point_y)
	);

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the elliptic arc point generator: random parameter
// beats under bursty input and stalled output, points checked against an
// in-bench fixed-point arc predictor over several arc settings.
// ----------------------------------------------------------------------------
module tb_top;
	import eap_pkg::*;

	localparam int STAGES  = 16;
	localparam int LATENCY = STAGES + 11;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	always #5 clk = ~clk;

	eap_sample_if sample_ch ();
	eap_point_if  point_ch ();
	eap_cfg_if    cfg_ch ();

	ellipse_arc_point #(.CORDIC_STAGES(STAGES)) u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.sample (sample_ch.sink),
		.point  (point_ch.source),
		.cfg    (cfg_ch.sink)
	);

	typedef struct {
		logic signed [31:0] px;
		logic signed [31:0] py;
	} arc_point_t;

	// ------------------------------------------------------------------
	// arc point predictor and store of expected points
	// ------------------------------------------------------------------
	class arc_scoreboard;
		arc_cfg_t   arc;
		arc_point_t pending[$];
		int         n_bad;

		function new();
			n_bad = 0;
			arc.center_x    = 0;
			arc.center_y    = 0;
			arc.radius_x    = 31'd65536;
			arc.radius_y    = 31'd65536;
			arc.start_angle = 0;
			arc.end_angle   = 24'sd411775;
			arc.clockwise   = 1'b0;
			arc.rotation    = 0;
		endfunction

		function void write_reg(reg_idx_t idx, logic [31:0] d);
			case (idx)
				REG_CENTER_X:    arc.center_x = d;
				REG_CENTER_Y:    arc.center_y = d;
				REG_RADIUS_X:    arc.radius_x = d[30:0];
				REG_RADIUS_Y:    arc.radius_y = d[30:0];
				REG_START_ANGLE: arc.start_angle = d[23:0];
				REG_END_ANGLE:   arc.end_angle = d[23:0];
				REG_CLOCKWISE:   arc.clockwise = d[0];
				REG_ROTATION:    arc.rotation = d[23:0];
				default: ;
			endcase
		endfunction

		static function longint fshr(longint v, int s);
			return v >>> s;
		endfunction

		static function longint atan_q30(int i);
			longint unsigned acc;
			longint unsigned term;
			int k;
			if (i == 0)
				return 64'd843314857;
			acc = 0;
			for (k = 0; i * (2 * k + 1) <= 62; k++) begin
				term = (64'd1 << (62 - i * (2 * k + 1))) / longint'(2 * k + 1);
				if (k % 2 == 1)
					acc = acc - term;
				else
					acc = acc + term;
			end
			return longint'((acc + (64'd1 << 31)) >> 32);
		endfunction

		static function void sin_cos(longint ang, output longint c, output longint s);
			longint z, x, y, xs, ys, a;
			bit flip;
			z = (ang * 16384) % Q30_TWO_PI;
			x = Q30_GAIN;
			y = 0;
			flip = 1'b0;
			if (z < 0)
				z += Q30_TWO_PI;
			if (z > Q30_PI)
				z -= Q30_TWO_PI;
			if (z > Q30_HALF_PI) begin
				z -= Q30_PI;
				flip = 1'b1;
			end else if (z < -Q30_HALF_PI) begin
				z += Q30_PI;
				flip = 1'b1;
			end
			for (int i = 0; i < STAGES; i++) begin
				xs = fshr(x, i);
				ys = fshr(y, i);
				a = atan_q30(i);
				if (z >= 0) begin
					x -= ys;
					y += xs;
					z -= a;
				end else begin
					x += ys;
					y -= xs;
					z += a;
				end
			end
			c = flip ? -x : x;
			s = flip ? -y : y;
		endfunction

		static function logic signed [31:0] clamp32(longint v);
			if (v > 64'sd2147483647)
				return 32'sh7fffffff;
			if (v < -64'sd2147483648)
				return 32'sh80000000;
			return v[31:0];
		endfunction

		function void note_param(logic [16:0] t);
			longint diff, span, ang, c, s, dx, dy, ox, oy, rc, rs;
			arc_point_t p;
			diff = longint'(arc.end_angle) - longint'(arc.start_angle);
			if (diff == 0) begin
				span = 0;
			end else begin
				span = diff % SPAN_TWO_PI;
				if (span < 0)
					span += SPAN_TWO_PI;
				if (span == 0)
					span = SPAN_TWO_PI;
				if (arc.clockwise)
					span = (span == SPAN_TWO_PI) ? -SPAN_TWO_PI : span - SPAN_TWO_PI;
			end
			ang = longint'(arc.start_angle) + fshr(longint'(t) * span + 32768, 16);
			sin_cos(ang, c, s);
			dx = fshr(longint'(arc.radius_x) * c + (64'sd1 << 29), 30);
			dy = fshr(longint'(arc.radius_y) * s + (64'sd1 << 29), 30);
			if (arc.rotation != 0) begin
				sin_cos(longint'(arc.rotation), rc, rs);
				ox = fshr(dx * rc - dy * rs + (64'sd1 << 29), 30);
				oy = fshr(dx * rs + dy * rc + (64'sd1 << 29), 30);
			end else begin
				ox = dx;
				oy = dy;
			end
			p.px = clamp32(longint'(arc.center_x) + ox);
			p.py = clamp32(longint'(arc.center_y) + oy);
			pending.push_back(p);
		endfunction

		function void check_point(logic signed [31:0] x, logic signed [31:0] y);
			arc_point_t e;
			if (pending.size() == 0) begin
				n_bad++;
				if (n_bad <= 10)
					$display("unexpected point beat x=%0d y=%0d", x, y);
				return;
			end
			e = pending.pop_front();
			if (x !== e.px || y !== e.py) begin
				n_bad++;
				if (n_bad <= 10)
					$display("point mismatch: expected x=%0d y=%0d, got x=%0d y=%0d",
						e.px, e.py, x, y);
			end
		endfunction
	endclass

	arc_scoreboard sb = new();

	// ------------------------------------------------------------------
	// point sink: stall pattern, check every accepted beat
	// ------------------------------------------------------------------
	int stall_mode = 0;
	int stall_cnt = 0;

	initial point_ch.ready = 1'b0;

	always @(posedge clk) begin
		if (arst_n && point_ch.valid && point_ch.ready)
			sb.check_point(point_ch.point_x, point_ch.point_y);
		if (stall_cnt == 0) begin
			stall_mode <= $urandom_range(0, 3);
			stall_cnt <= $urandom_range(5, 60);
		end else begin
			stall_cnt <= stall_cnt - 1;
		end
		case (stall_mode)
			0: point_ch.ready <= 1'b1;
			1: point_ch.ready <= ($urandom_range(0, 3) != 0);
			2: point_ch.ready <= ($urandom_range(0, 3) == 0);
			default: point_ch.ready <= (stall_cnt % 8) < 5;
		endcase
	end

	// ------------------------------------------------------------------
	// drivers
	// ------------------------------------------------------------------
	int gap_left = 0;

	task automatic send_param(logic [16:0] t);
		// random gap between bursts
		if (gap_left == 0 && $urandom_range(0, 7) == 0) begin
			sample_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
		end
		gap_left = (gap_left == 0) ? $urandom_range(1, 30) : gap_left - 1;
		sample_ch.valid   <= 1'b1;
		sample_ch.param_t <= t;
		do
			@(posedge clk);
		while (!sample_ch.ready);
		sb.note_param(t);
	endtask

	task automatic send_idle();
		sample_ch.valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic write_reg(reg_idx_t idx, logic [31:0] d);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data  <= d;
		do
			@(posedge clk);
		while (!cfg_ch.ready);
		sb.write_reg(idx, d);
		cfg_ch.valid <= 1'b0;
	endtask

	task automatic drain();
		send_idle();
		while (sb.pending.size() != 0)
			@(posedge clk);
		repeat (LATENCY + 4) @(posedge clk);
	endtask

	function automatic logic [16:0] rand_param();
		case ($urandom_range(0, 9))
			0: return 17'd0;
			1: return 17'd65536;
			2: return $urandom_range(65537, 131071);
			default: return $urandom_range(0, 65536);
		endcase
	endfunction

	function automatic logic [31:0] rand_angle();
		case ($urandom_range(0, 5))
			0: return 32'h007fffff;
			1: return 32'hff800000;
			2: return 32'd0;
			3: return $urandom_range(0, 411775 * 2) - 411775;
			default: return $urandom();
		endcase
	endfunction

	function automatic logic [31:0] rand_radius();
		case ($urandom_range(0, 4))
			0: return 32'h7fffffff;
			1: return 32'd0;
			2: return $urandom();
			default: return $urandom_range(0, 32'h00ffffff);
		endcase
	endfunction

	function automatic logic [31:0] rand_center();
		case ($urandom_range(0, 4))
			0: return 32'h7fffffff;
			1: return 32'h80000000;
			2: return $urandom();
			default: return $urandom_range(0, 32'h01ffffff) - 32'h00ffffff;
		endcase
	endfunction

	task automatic random_arc();
		write_reg(REG_CENTER_X, rand_center());
		write_reg(REG_CENTER_Y, rand_center());
		write_reg(REG_RADIUS_X, rand_radius());
		write_reg(REG_RADIUS_Y, rand_radius());
		write_reg(REG_START_ANGLE, rand_angle());
		// equal start and end now and then: zero span
		if ($urandom_range(0, 5) == 0)
			write_reg(REG_END_ANGLE, {{8{sb.arc.start_angle[23]}}, sb.arc.start_angle});
		else if ($urandom_range(0, 5) == 0)
			write_reg(REG_END_ANGLE, sb.arc.start_angle + 24'sd411775 * $urandom_range(1, 3));
		else
			write_reg(REG_END_ANGLE, rand_angle());
		write_reg(REG_CLOCKWISE, $urandom());
		write_reg(REG_ROTATION, ($urandom_range(0, 2) == 0) ? 32'd0 : rand_angle());
	endtask

	// ------------------------------------------------------------------
	// stimulus
	// ------------------------------------------------------------------
	initial begin
		sample_ch.valid   = 1'b0;
		sample_ch.param_t = '0;
		cfg_ch.valid      = 1'b0;
		cfg_ch.index      = REG_CENTER_X;
		cfg_ch.data       = '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset arc: full turn, extremes of t
		send_param(17'd0);
		send_param(17'd65536);
		send_param(17'd32768);
		send_param(17'd131071);
		send_param(17'd1);
		drain();

		// extreme registers, clockwise arc, rotation, saturation
		write_reg(REG_CENTER_X, 32'h7fffffff);
		write_reg(REG_CENTER_Y, 32'h80000000);
		write_reg(REG_RADIUS_X, 32'hffffffff);
		write_reg(REG_RADIUS_Y, 32'h7fffffff);
		write_reg(REG_START_ANGLE, 32'hff800000);
		write_reg(REG_END_ANGLE, 32'h007fffff);
		write_reg(REG_CLOCKWISE, 32'd1);
		write_reg(REG_ROTATION, 32'h007fffff);
		send_param(17'd0);
		send_param(17'd65536);
		send_param(17'd131071);
		send_param(17'd21845);
		drain();
		write_reg(REG_CENTER_X, 32'd0);
		write_reg(REG_CENTER_Y, 32'd0);
		write_reg(REG_START_ANGLE, 32'd0);
		write_reg(REG_END_ANGLE, 32'd823550);   // two whole turns
		write_reg(REG_ROTATION, 32'hff800000);
		send_param(17'd16384);
		send_param(17'd65536);
		drain();
		write_reg(REG_CLOCKWISE, 32'd0);
		write_reg(REG_END_ANGLE, 32'd0);        // zero span
		write_reg(REG_ROTATION, 32'd0);
		send_param(17'd65536);
		send_param(17'd98304);
		drain();

		for (int ph = 0; ph < 22; ph++) begin
			random_arc();
			for (int n = 0; n < 50; n++)
				send_param(rand_param());
			drain();
		end

		if (sb.n_bad == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

	initial begin
		#5ms;
		$display("*** FAILED ***");
		$finish;
	end
endmodule
